[src/tlvp_pkg.sv]
package tlvp_pkg;

  localparam int TAG_COUNT = 256;
  localparam int TAG_IDX_W = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CFG_FIRST_LV_TAG = 8'd0;
  localparam logic [7:0] CFG_SECOND_LV_TAG = 8'd1;

  localparam logic CMD_DEFINE = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic [7:0] LEN16_SHORT_FLAG = 8'h80;
  localparam logic [7:0] LEN7_MASK = 8'h7f;

  typedef enum logic [2:0] {
    TY_NONE  = 3'd0,
    TY_T     = 3'd1,
    TY_TV    = 3'd2,
    TY_FIXED = 3'd3,
    TY_TLV   = 3'd4,
    TY_TVLV  = 3'd5,
    TY_TL16V = 3'd6,
    TY_BAD   = 3'd7
  } tlvp_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC_HDR = 2'd1,
    ST_OVERRUN   = 2'd2,
    ST_UNKNOWN   = 2'd3
  } tlvp_status_t;

  // One message byte with the definition of the tag it would be if read as a tag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    tlvp_type_t ty;
    logic [7:0] flen;
  } tlvp_item_t;

  typedef struct packed {
    logic         is_element;
    tlvp_status_t status;
    logic [7:0]   tag;
    logic [15:0]  len;
    logic [15:0]  off;
    logic [15:0]  count;
    logic         eom;
  } tlvp_result_t;

endpackage

[src/tlv_information_element_parser_unit.sv]
// A result is shown on the master side once the byte that completes it has passed the
// front stage, the queue and the result register pair; a definition request gives no
// result. Throughput: one request per cycle while results are taken; a byte that gives
// two results (an element and the end report) holds input until both leave the pair.
// Reset is synchronous: it marks every definition table entry as type none at once, with
// no clearing pass, and returns the parser to the start of a message.
module tlv_information_element_parser_unit import tlvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // def_tag[7:0], def_type[10:8], def_fixed_len[18:11],
                                // data_byte[26:19], zero[31:27]
  input  logic        s_tuser,  // cmd
  input  logic        s_tlast,  // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // status[1:0], element_tag[9:2], value_length[25:10],
                                // value_offset[41:26], element_count[57:42], zero[63:58]
  output logic        m_tuser,  // is_element
  output logic        m_tlast,  // end_of_message
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic         [7:0] first_lv_tag;
  logic         [7:0] second_lv_tag;
  logic               f_valid;
  logic               f_ready;
  tlvp_item_t         f_item;
  logic               q_valid;
  logic               q_pop;
  tlvp_item_t         q_item;
  tlvp_result_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_lv_tag  <= 8'd0;
      second_lv_tag <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FIRST_LV_TAG) begin
        first_lv_tag <= cfg_data;
      end else if (cfg_index == CFG_SECOND_LV_TAG) begin
        second_lv_tag <= cfg_data;
      end
    end
  end

  tlvp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .cmd          (s_tuser),
    .def_tag      (s_tdata[7:0]),
    .def_type     (s_tdata[10:8]),
    .def_fixed_len(s_tdata[18:11]),
    .data_byte    (s_tdata[26:19]),
    .last_byte    (s_tlast),
    .item_valid   (f_valid),
    .item         (f_item),
    .item_ready   (f_ready)
  );

  tlvp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_item (f_item),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  tlvp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .first_lv_tag (first_lv_tag),
    .second_lv_tag(second_lv_tag),
    .item_valid   (q_valid),
    .item_pop     (q_pop),
    .item         (q_item),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .res          (res)
  );

  assign m_tdata = {6'd0, res.count, res.off, res.len, res.tag, res.status};
  assign m_tuser = res.is_element;
  assign m_tlast = res.eom;

endmodule

[src/tlvp_front.sv]
module tlvp_front import tlvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic [7:0] def_tag,
  input  logic [2:0] def_type,
  input  logic [7:0] def_fixed_len,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       item_valid,
  output tlvp_item_t item,
  input  logic       item_ready
);

  logic [10:0]          mem [TAG_COUNT];
  logic [TAG_COUNT-1:0] tab_valid;
  logic [10:0]          rd_entry;
  logic                 rd_ok;
  logic                 s1_valid;
  logic [7:0]           s1_data;
  logic                 s1_last;
  logic                 acc;
  logic                 def_known;
  logic                 byte_known;

  assign in_ready   = !s1_valid || item_ready;
  assign acc        = in_valid && in_ready;
  assign def_known  = ({1'b0, def_tag} < 9'(TAG_COUNT));
  assign byte_known = ({1'b0, data_byte} < 9'(TAG_COUNT));

  // Definition table: written by definition requests, read once for every message byte.
  always_ff @(posedge clk) begin
    if (acc && cmd == CMD_DEFINE && def_known) begin
      mem[def_tag[TAG_IDX_W-1:0]] <= {def_type, def_fixed_len};
    end
    if (acc && cmd == CMD_BYTE) begin
      rd_entry <= mem[data_byte[TAG_IDX_W-1:0]];
      s1_data  <= data_byte;
      s1_last  <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_valid <= '0;
      rd_ok     <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      if (acc && cmd == CMD_DEFINE && def_known) begin
        tab_valid[def_tag[TAG_IDX_W-1:0]] <= 1'b1;
      end
      if (acc && cmd == CMD_BYTE) begin
        rd_ok    <= byte_known && tab_valid[data_byte[TAG_IDX_W-1:0]];
        s1_valid <= 1'b1;
      end else if (item_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // An entry never written reads as type none.
  assign item_valid = s1_valid;
  assign item.data  = s1_data;
  assign item.last  = s1_last;
  assign item.ty    = rd_ok ? tlvp_type_t'(rd_entry[10:8]) : TY_NONE;
  assign item.flen  = rd_ok ? rd_entry[7:0] : 8'd0;

endmodule

[src/tlvp_queue.sv]
module tlvp_queue import tlvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  tlvp_item_t push_item,
  output logic       pop_valid,
  input  logic       pop,
  output tlvp_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tlvp_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count < CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/tlvp_back.sv]
module tlvp_back import tlvp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   first_lv_tag,
  input  logic [7:0]   second_lv_tag,
  input  logic         item_valid,
  output logic         item_pop,
  input  tlvp_item_t   item,
  output logic         res_valid,
  input  logic         res_ready,
  output tlvp_result_t res
);

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_LV1_LEN  = 4'd1,
    PH_LV2_LEN  = 4'd2,
    PH_POST1    = 4'd3,
    PH_TAG      = 4'd4,
    PH_TLV_LEN  = 4'd5,
    PH_TVLV_LEN = 4'd6,
    PH_L16_HI   = 4'd7,
    PH_L16_LO   = 4'd8,
    PH_VAL1     = 4'd9,
    PH_VAL      = 4'd10
  } phase_t;

  phase_t       phase, ph, phase_next, bv_val, bv_done;
  logic [7:0]   cur_tag, tag_next;
  logic [15:0]  rem, rem_next, rem_dec;
  logic [15:0]  byte_offset;
  logic [15:0]  parsed_count, count_next;
  logic         err, err_next;
  logic [15:0]  elem_len, len_next;
  logic [15:0]  elem_off, off_next;
  logic         emit;
  logic         bv_go;
  logic [15:0]  bv_len, bv_off;
  tlvp_status_t end_status;
  tlvp_result_t elem_res, end_res;
  tlvp_result_t r0, r1;
  logic         r0v, r1v;
  logic         taken;
  logic         load_ok;
  logic [7:0]   b;

  assign b        = item.data;
  assign res_valid = r0v || r1v;
  assign res       = r0v ? r0 : r1;
  assign taken     = res_valid && res_ready;
  // The result pair is reloaded once it is empty or its last result leaves now.
  assign load_ok   = !res_valid || (taken && !(r0v && r1v));
  assign item_pop  = item_valid && load_ok;

  always_comb begin
    ph = phase;
    if (!err) begin
      if (phase == PH_START) begin
        ph = (first_lv_tag != 8'd0) ? PH_LV1_LEN :
             ((second_lv_tag != 8'd0) ? PH_LV2_LEN : PH_TAG);
      end else if (phase == PH_POST1) begin
        ph = (second_lv_tag != 8'd0) ? PH_LV2_LEN : PH_TAG;
      end
    end
    phase_next = ph;
    tag_next   = cur_tag;
    rem_next   = rem;
    err_next   = err;
    len_next   = elem_len;
    off_next   = elem_off;
    emit       = 1'b0;
    bv_go      = 1'b0;
    bv_len     = 16'd0;
    bv_off     = byte_offset + 16'd1;
    bv_val     = PH_VAL;
    bv_done    = PH_TAG;
    rem_dec    = (rem != 16'd0) ? rem - 16'd1 : rem;
    if (!err) begin
      case (ph)
        PH_LV1_LEN: begin
          tag_next = first_lv_tag;
          bv_go    = 1'b1;
          bv_len   = {8'd0, b};
          bv_val   = PH_VAL1;
          bv_done  = PH_POST1;
        end
        PH_LV2_LEN: begin
          tag_next = second_lv_tag;
          bv_go    = 1'b1;
          bv_len   = {8'd0, b};
        end
        PH_TAG: begin
          tag_next = b;
          case (item.ty)
            TY_T: begin
              bv_go  = 1'b1;
              bv_off = byte_offset;
            end
            TY_TV: begin
              bv_go  = 1'b1;
              bv_len = 16'd1;
            end
            TY_FIXED: begin
              bv_go  = 1'b1;
              bv_len = {8'd0, item.flen};
            end
            TY_TLV:   phase_next = PH_TLV_LEN;
            TY_TVLV:  phase_next = PH_TVLV_LEN;
            TY_TL16V: phase_next = PH_L16_HI;
            default:  err_next = 1'b1;
          endcase
        end
        PH_TLV_LEN: begin
          bv_go  = 1'b1;
          bv_len = {8'd0, b};
        end
        PH_TVLV_LEN: begin
          // A set top bit gives a short length; otherwise this is the high byte.
          if ((b & LEN16_SHORT_FLAG) != 8'd0) begin
            bv_go  = 1'b1;
            bv_len = {8'd0, b & LEN7_MASK};
          end else begin
            rem_next   = {8'd0, b};
            phase_next = PH_L16_LO;
          end
        end
        PH_L16_HI: begin
          rem_next   = {8'd0, b};
          phase_next = PH_L16_LO;
        end
        PH_L16_LO: begin
          bv_go  = 1'b1;
          bv_len = {rem[7:0], b};
        end
        PH_VAL1, PH_VAL: begin
          rem_next = rem_dec;
          if (rem_dec == 16'd0) begin
            emit       = 1'b1;
            phase_next = (ph == PH_VAL1) ? PH_POST1 : PH_TAG;
          end
        end
        default: phase_next = PH_TAG;
      endcase
    end
    if (bv_go) begin
      len_next = bv_len;
      off_next = bv_off;
      if (bv_len == 16'd0) begin
        emit       = 1'b1;
        phase_next = bv_done;
      end else begin
        rem_next   = bv_len;
        phase_next = bv_val;
      end
    end
    count_next = (emit && parsed_count != 16'hffff) ? parsed_count + 16'd1 : parsed_count;
  end

  always_comb begin
    if (err_next) begin
      end_status = ST_UNKNOWN;
    end else begin
      case (phase_next)
        PH_POST1:    end_status = (second_lv_tag != 8'd0) ? ST_TRUNC_HDR : ST_OK;
        PH_VAL1,
        PH_VAL:      end_status = ST_OVERRUN;
        PH_TLV_LEN,
        PH_TVLV_LEN,
        PH_L16_HI,
        PH_L16_LO,
        PH_LV1_LEN,
        PH_LV2_LEN:  end_status = ST_TRUNC_HDR;
        default:     end_status = ST_OK;
      endcase
    end
  end

  always_comb begin
    elem_res.is_element = 1'b1;
    elem_res.status     = ST_OK;
    elem_res.tag        = tag_next;
    elem_res.len        = len_next;
    elem_res.off        = off_next;
    elem_res.count      = count_next;
    elem_res.eom        = 1'b0;
    end_res.is_element  = 1'b0;
    end_res.status      = end_status;
    end_res.tag         = 8'd0;
    end_res.len         = 16'd0;
    end_res.off         = 16'd0;
    end_res.count       = count_next;
    end_res.eom         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      r0 <= emit ? elem_res : end_res;
      r1 <= end_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      cur_tag      <= 8'd0;
      rem          <= 16'd0;
      byte_offset  <= 16'd0;
      parsed_count <= 16'd0;
      err          <= 1'b0;
      elem_len     <= 16'd0;
      elem_off     <= 16'd0;
      r0v          <= 1'b0;
      r1v          <= 1'b0;
    end else begin
      if (item_pop) begin
        r0v <= emit || item.last;
        r1v <= emit && item.last;
        if (item.last) begin
          phase        <= PH_START;
          cur_tag      <= 8'd0;
          rem          <= 16'd0;
          byte_offset  <= 16'd0;
          parsed_count <= 16'd0;
          err          <= 1'b0;
          elem_len     <= 16'd0;
          elem_off     <= 16'd0;
        end else begin
          phase        <= phase_next;
          cur_tag      <= tag_next;
          rem          <= rem_next;
          byte_offset  <= byte_offset + 16'd1;
          parsed_count <= count_next;
          err          <= err_next;
          elem_len     <= len_next;
          elem_off     <= off_next;
        end
      end else if (taken) begin
        if (r0v) begin
          r0v <= 1'b0;
        end else begin
          r1v <= 1'b0;
        end
      end
    end
  end

endmodule

[src/tlvp_checker.sv]
module tlvp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Every result is either an element report or an end report, never both.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != m_tlast))
    else $error("result kind and end marker disagree");

  // End reports carry no tag, length or offset.
  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[41:2] == 40'd0))
    else $error("end report carries element fields");

  // Element reports are always good, and the padding stays clear.
  a_elem_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:58] == 6'd0) && (!m_tuser || m_tdata[1:0] == 2'd0))
    else $error("bad element status or padding");

endmodule

bind tlv_information_element_parser_unit tlvp_checker u_tlvp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 80;
  localparam int PHASE_BYTES = 130;

  typedef enum logic [3:0] {
    P_START, P_LV1_LEN, P_LV2_LEN, P_AFTER_LV1, P_TAG, P_TLV_LEN, P_TVLV_LEN,
    P_L16_HI, P_L16_LO, P_LV1_VALUE, P_VALUE
  } parse_phase_t;

  typedef struct packed {
    logic         cmd;
    logic [7:0]   tag;
    tlvp_type_t   ty;
    logic [7:0]   flen;
    logic [7:0]   data;
    logic         last;
    logic         typed;
    tlvp_status_t exp_status;
    logic [15:0]  exp_count;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  tlv_information_element_parser_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Parser mirror: definition table, leading LV tags and per-message state.
  tlvp_type_t   dt_type [TAG_COUNT];
  logic [7:0]   dt_len [TAG_COUNT];
  logic [7:0]   lv1_tag = '0;
  logic [7:0]   lv2_tag = '0;
  parse_phase_t phase = P_START;
  logic [7:0]   cur_tag;
  logic [16:0]  remaining;
  logic [16:0]  msg_offset;
  logic [16:0]  el_off;
  logic [15:0]  el_len;
  logic [15:0]  el_count;
  logic         err_latched;
  tlvp_result_t pred_res [2];
  int           pred_n;

  tlvp_result_t report_q[$];

  // Request side bookkeeping, stimulus generation and statistics.
  logic         drv_typed = 1'b0;
  tlvp_status_t drv_status = ST_OK;
  logic [15:0]  drv_count = '0;
  tlvp_type_t   gen_ty [256];
  logic [7:0]   gen_len [256];
  logic [7:0]   gen_lv1 = '0;
  logic [7:0]   gen_lv2 = '0;
  logic [7:0]   msg[$];
  bit           calm_tail = 1'b0;
  int           holds_requested = 0;
  int           holds_served = 0;
  int           stall_left = 0;
  int           failures = 0;
  int           idle_cycles = 0;
  int           n_bytes = 0;
  int           n_defs = 0;
  int           n_msgs = 0;
  int           n_settings = 0;
  int           n_elements = 0;
  int           n_end [4] = '{0, 0, 0, 0};

  stim_row_t directed [23] = '{
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h05, 1'b1, 1'b1, ST_UNKNOWN,   16'd0},
    '{CMD_DEFINE, 8'h01, TY_T,     8'h00, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_DEFINE, 8'h02, TY_TV,    8'h00, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_DEFINE, 8'h03, TY_FIXED, 8'h03, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_DEFINE, 8'h04, TY_TLV,   8'h00, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_DEFINE, 8'h05, TY_TVLV,  8'h00, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_DEFINE, 8'h06, TY_TL16V, 8'h00, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_DEFINE, 8'hff, TY_FIXED, 8'hff, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_DEFINE, 8'h07, TY_BAD,   8'h00, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h01, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h02, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'hff, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h05, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h81, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h11, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h06, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h00, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h00, 1'b1, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h04, 1'b1, 1'b1, ST_TRUNC_HDR, 16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h02, 1'b1, 1'b1, ST_OVERRUN,   16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h07, 1'b1, 1'b1, ST_UNKNOWN,   16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h03, 1'b0, 1'b0, ST_OK,        16'd0},
    '{CMD_BYTE,   8'h00, TY_NONE,  8'h00, 8'h11, 1'b1, 1'b1, ST_OVERRUN,   16'd0}
  };

  task automatic clear_message();
    phase = P_START;
    cur_tag = '0;
    remaining = '0;
    msg_offset = '0;
    el_count = '0;
    err_latched = 1'b0;
    el_len = '0;
    el_off = '0;
  endtask

  function automatic parse_phase_t after_lv1();
    return (lv2_tag != 0) ? P_LV2_LEN : P_TAG;
  endfunction

  task automatic emit_element();
    if (el_count != 16'hffff) el_count++;
    pred_res[pred_n] = '{1'b1, ST_OK, cur_tag, el_len, el_off[15:0], el_count, 1'b0};
    pred_n++;
  endtask

  task automatic start_value(input logic [15:0] len, input logic [16:0] off,
                             input parse_phase_t val_ph, input parse_phase_t done_ph);
    el_len = len;
    el_off = off;
    if (len == 0) begin
      emit_element();
      phase = done_ph;
    end else begin
      remaining = {1'b0, len};
      phase = val_ph;
    end
  endtask

  task automatic parse_request(input logic cmd, input logic [7:0] tag, input tlvp_type_t ty,
                               input logic [7:0] flen, input logic [7:0] data,
                               input logic last);
    logic [16:0]  ofs;
    tlvp_type_t   ty_rd;
    logic [7:0]   fl_rd;
    tlvp_status_t st;
    ofs = msg_offset;
    pred_n = 0;
    if (cmd == CMD_DEFINE) begin
      if (int'(tag) < TAG_COUNT) begin
        dt_type[tag] = ty;
        dt_len[tag] = flen;
      end
    end else begin
      if (!err_latched) begin
        if (phase == P_START) phase = (lv1_tag != 0) ? P_LV1_LEN : after_lv1();
        else if (phase == P_AFTER_LV1) phase = after_lv1();
        case (phase)
          P_LV1_LEN: begin
            cur_tag = lv1_tag;
            start_value({8'd0, data}, ofs + 17'd1, P_LV1_VALUE, P_AFTER_LV1);
          end
          P_LV2_LEN: begin
            cur_tag = lv2_tag;
            start_value({8'd0, data}, ofs + 17'd1, P_VALUE, P_TAG);
          end
          P_TAG: begin
            cur_tag = data;
            ty_rd = TY_NONE;
            fl_rd = '0;
            if (int'(data) < TAG_COUNT) begin
              ty_rd = dt_type[data];
              fl_rd = dt_len[data];
            end
            case (ty_rd)
              TY_T:     start_value(16'd0, ofs, P_VALUE, P_TAG);
              TY_TV:    start_value(16'd1, ofs + 17'd1, P_VALUE, P_TAG);
              TY_FIXED: start_value({8'd0, fl_rd}, ofs + 17'd1, P_VALUE, P_TAG);
              TY_TLV:   phase = P_TLV_LEN;
              TY_TVLV:  phase = P_TVLV_LEN;
              TY_TL16V: phase = P_L16_HI;
              default:  err_latched = 1'b1;
            endcase
          end
          P_TLV_LEN: start_value({8'd0, data}, ofs + 17'd1, P_VALUE, P_TAG);
          P_TVLV_LEN: begin
            // Bit 7 set means a short length; clear means the high byte of a long one.
            if ((data & LEN16_SHORT_FLAG) != 0) begin
              start_value({8'd0, data & LEN7_MASK}, ofs + 17'd1, P_VALUE, P_TAG);
            end else begin
              remaining = {9'd0, data};
              phase = P_L16_LO;
            end
          end
          P_L16_HI: begin
            remaining = {9'd0, data};
            phase = P_L16_LO;
          end
          P_L16_LO: start_value({remaining[7:0], data}, ofs + 17'd1, P_VALUE, P_TAG);
          P_LV1_VALUE, P_VALUE: begin
            if (remaining != 0) remaining--;
            if (remaining == 0) begin
              emit_element();
              phase = (phase == P_LV1_VALUE) ? P_AFTER_LV1 : P_TAG;
            end
          end
          default: phase = P_TAG;
        endcase
      end
      msg_offset = msg_offset + 17'd1;
      if (last) begin
        st = ST_OK;
        if (err_latched) st = ST_UNKNOWN;
        else if (phase == P_AFTER_LV1) st = (lv2_tag != 0) ? ST_TRUNC_HDR : ST_OK;
        else if (phase == P_LV1_VALUE || phase == P_VALUE) st = ST_OVERRUN;
        else if (phase != P_TAG && phase != P_START) st = ST_TRUNC_HDR;
        pred_res[pred_n] = '{1'b0, st, 8'd0, 16'd0, 16'd0, el_count, 1'b1};
        pred_n++;
        clear_message();
      end
    end
  endtask

  // Everything is sampled at the rising edge: the mirror takes accepted requests, and
  // each accepted report is checked against the oldest one waiting.
  always @(posedge clk) begin : monitor
    tlvp_result_t seen;
    tlvp_result_t want;
    bit           moved;
    if (rst) begin
      for (int i = 0; i < TAG_COUNT; i++) begin
        dt_type[i] = TY_NONE;
        dt_len[i] = '0;
      end
      lv1_tag = '0;
      lv2_tag = '0;
      clear_message();
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == CFG_FIRST_LV_TAG) lv1_tag = cfg_data;
        else if (cfg_index == CFG_SECOND_LV_TAG) lv2_tag = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        parse_request(s_tuser, s_tdata[7:0], tlvp_type_t'(s_tdata[10:8]), s_tdata[18:11],
                      s_tdata[26:19], s_tlast);
        if (drv_typed) begin
          report_q.push_back('{1'b0, drv_status, 8'd0, 16'd0, 16'd0, drv_count, 1'b1});
        end else begin
          for (int k = 0; k < pred_n; k++) report_q.push_back(pred_res[k]);
        end
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        seen.is_element = m_tuser;
        seen.status = tlvp_status_t'(m_tdata[1:0]);
        seen.tag = m_tdata[9:2];
        seen.len = m_tdata[25:10];
        seen.off = m_tdata[41:26];
        seen.count = m_tdata[57:42];
        seen.eom = m_tlast;
        if (report_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: report with nothing outstanding: el=%0b st=%0d tag=%h len=%0d",
                     $realtime, seen.is_element, seen.status, seen.tag, seen.len);
        end else begin
          want = report_q.pop_front();
          if (want.is_element) n_elements++;
          else n_end[want.status]++;
          if (seen !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: report mismatch", $realtime);
              $display("  expected el=%0b st=%0d tag=%h len=%0d off=%0d cnt=%0d eom=%0b",
                       want.is_element, want.status, want.tag, want.len, want.off,
                       want.count, want.eom);
              $display("  actual   el=%0b st=%0d tag=%h len=%0d off=%0d cnt=%0d eom=%0b",
                       seen.is_element, seen.status, seen.tag, seen.len, seen.off,
                       seen.count, seen.eom);
            end
          end
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
                 idle_cycles, report_q.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Report side back-pressure: short random stalls, plus a long hold on request.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      stall_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] tag, input tlvp_type_t ty,
                           input logic [7:0] flen, input logic [7:0] data, input logic last,
                           input logic typed, input tlvp_status_t tst,
                           input logic [15:0] tcount);
    int gap;
    gap = 0;
    if (!calm_tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {5'd0, data, flen, ty, tag};
    s_tlast <= last;
    drv_typed <= typed;
    drv_status <= tst;
    drv_count <= tcount;
    if (cmd == CMD_DEFINE) begin
      gen_ty[tag] = ty;
      gen_len[tag] = flen;
      n_defs++;
    end else begin
      n_bytes++;
      if (last) n_msgs++;
    end
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering requests and wait until every report has come back.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_definition(input logic [7:0] tag, input tlvp_type_t ty,
                                 input logic [7:0] flen);
    send_item(CMD_DEFINE, tag, ty, flen, 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'b0, ST_OK, 16'd0);
  endtask

  function automatic int pick_len(input int hi);
    return ($urandom_range(0, 15) == 0) ? $urandom_range(0, hi) : $urandom_range(0, 5);
  endfunction

  task automatic add_value(input int n);
    repeat (n) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_message();
    logic [7:0] valid_tags[$];
    logic [7:0] t;
    int         n_el;
    int         l;
    msg.delete();
    for (int i = 0; i < 256; i++)
      if (gen_ty[i] != TY_NONE && gen_ty[i] != TY_BAD) valid_tags.push_back(8'(i));
    if (gen_lv1 != 0) begin
      l = pick_len(255);
      msg.push_back(8'(l));
      add_value(l);
    end
    if (gen_lv2 != 0) begin
      l = pick_len(255);
      msg.push_back(8'(l));
      add_value(l);
    end
    n_el = (valid_tags.size() == 0) ? 0 : $urandom_range(1, 5);
    repeat (n_el) begin
      t = valid_tags[$urandom_range(0, valid_tags.size() - 1)];
      msg.push_back(t);
      case (gen_ty[t])
        TY_TV:    add_value(1);
        TY_FIXED: add_value(gen_len[t]);
        TY_TLV: begin
          l = pick_len(255);
          msg.push_back(8'(l));
          add_value(l);
        end
        TY_TVLV: begin
          if ($urandom_range(0, 1) == 1) begin
            l = pick_len(127);
            msg.push_back(8'(l) | LEN16_SHORT_FLAG);
          end else begin
            l = pick_len(300);
            msg.push_back(8'(l >> 8));
            msg.push_back(8'(l));
          end
          add_value(l);
        end
        TY_TL16V: begin
          l = pick_len(300);
          msg.push_back(8'(l >> 8));
          msg.push_back(8'(l));
          add_value(l);
        end
        default: ;
      endcase
    end
    if (msg.size() == 0) add_value(1);
  endtask

  // Mostly well-formed messages; some cut short or corrupted, a few pure noise.
  task automatic send_message();
    int pick;
    int cut;
    pick = $urandom_range(0, 9);
    build_message();
    if (pick >= 9) begin
      msg.delete();
      add_value($urandom_range(1, 6));
    end else if (pick >= 7) begin
      if (msg.size() > 1 && $urandom_range(0, 1) == 1) begin
        cut = $urandom_range(1, msg.size() - 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end else begin
        msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    for (int i = 0; i < msg.size(); i++)
      send_item(CMD_BYTE, 8'($urandom_range(0, 255)), tlvp_type_t'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), msg[i], i == msg.size() - 1, 1'b0, ST_OK, 16'd0);
  endtask

  initial begin : stimulus
    logic [7:0] lv1_set [7];
    logic [7:0] lv2_set [7];
    logic [7:0] fl;
    int         budget;
    int         sent;
    lv1_set = '{8'h00, 8'hff, 8'h01, 8'h00, 8'hff, 8'h00, 8'h5a};
    lv2_set = '{8'h00, 8'h00, 8'h80, 8'h33, 8'hff, 8'h00, 8'h00};
    for (int i = 0; i < 256; i++) begin
      gen_ty[i] = TY_NONE;
      gen_len[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].tag, directed[i].ty, directed[i].flen,
                directed[i].data, directed[i].last, directed[i].typed,
                directed[i].exp_status, directed[i].exp_count);

    for (int p = 0; p < 7; p++) begin
      drain();
      if (p == 5) begin
        lv1_set[p] = 8'($urandom_range(0, 255));
        lv2_set[p] = 8'($urandom_range(0, 255));
      end
      write_reg(CFG_FIRST_LV_TAG, lv1_set[p]);
      write_reg(CFG_SECOND_LV_TAG, lv2_set[p]);
      gen_lv1 = lv1_set[p];
      gen_lv2 = lv2_set[p];
      n_settings++;
      for (int t = 1; t <= 6; t++) begin
        fl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 4));
        send_definition(8'($urandom_range(0, 255)), tlvp_type_t'(t), fl);
      end
      repeat (4)
        send_definition(8'($urandom_range(0, 255)), tlvp_type_t'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255)));
      if (p == 6) calm_tail = 1'b1;
      budget = n_bytes + PHASE_BYTES;
      sent = 0;
      while (n_bytes < budget) begin
        send_message();
        sent++;
        // Hold the report side off while requests keep coming, so the parser backs up.
        if (p == 1 && sent == 3) holds_requested++;
        if (p == 2 && sent == 3) drain();
        if ($urandom_range(0, 19) == 0)
          send_definition(8'($urandom_range(0, 255)), tlvp_type_t'($urandom_range(0, 7)),
                          8'($urandom_range(0, 5)));
      end
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d message bytes in %0d messages, %0d table writes, %0d tag settings.",
             n_bytes, n_msgs, n_defs, n_settings);
    $display("Checked %0d elements; end reports ok/header/overrun/unknown %0d/%0d/%0d/%0d.",
             n_elements, n_end[0], n_end[1], n_end[2], n_end[3]);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d failures", failures);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/tlvp_pkg.sv
src/tlvp_front.sv
src/tlvp_queue.sv
src/tlvp_back.sv
src/tlv_information_element_parser_unit.sv
src/tlvp_checker.sv
tb/sv/testbench.sv
